FILE: hw/rtl/pmfd_pkg.sv
// Shared types and constants for the power meter frame decoder.
package pmfd_pkg;

   localparam int FRAME_BYTES   = 24;
   localparam int WORD_COUNT    = 6;
   localparam int WORD_W        = 24;
   localparam int Q_W           = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'h5A;

   localparam logic [4:0] LAST_SUM_IDX  = 5'(FRAME_BYTES - 3);
   localparam logic [2:0] WORD_CNT_CODE = 3'(WORD_COUNT);

   localparam logic [1:0] CSR_MIN_VOLTAGE    = 2'd0;
   localparam logic [1:0] CSR_POWER_MARGIN   = 2'd1;
   localparam logic [1:0] CSR_CURRENT_MARGIN = 2'd2;

   localparam logic [15:0] MIN_VOLTAGE_RST    = 16'd20;
   localparam logic [3:0]  POWER_MARGIN_RST   = 4'd2;
   localparam logic [5:0]  CURRENT_MARGIN_RST = 6'd10;

   typedef logic [WORD_COUNT-1:0][WORD_W-1:0] words_type;

   typedef struct packed {
      logic [15:0] min_voltage;
      logic [3:0]  power_margin;
      logic [5:0]  current_margin;
   } cfg_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [1:0] count;
   } queue_stat_type;

   typedef enum logic [1:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      HUNT_COLLECT
   } hunt_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_WAIT,
      BK_MUL,
      BK_CMP,
      BK_SEND
   } back_state_type;

endpackage

FILE: hw/rtl/pmfd_front.sv
// Front end: sync hunt, byte collection, checksum and word assembly.
module pmfd_front
   import pmfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       q_full,
   output logic       push,
   output words_type  push_words
);

   hunt_type   phase_ff, phase_in;
   logic [4:0] idx_ff, idx_in;
   logic [7:0] sum_ff, sum_in;
   logic [2:0] wsel_ff, wsel_in;
   logic [1:0] wsub_ff, wsub_in;
   words_type  words_ff;
   logic       accept;
   logic       shift_word;

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign push_words = words_ff;

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      wsel_in    = wsel_ff;
      wsub_in    = wsub_ff;
      push       = 1'b0;
      shift_word = 1'b0;
      if (accept) begin
         case (phase_ff)
            HUNT_SECOND: begin
               phase_in = (req_rx_byte == SYNC_SECOND) ? HUNT_COLLECT : HUNT_FIRST;
               idx_in   = '0;
               sum_in   = '0;
               wsel_in  = '0;
               wsub_in  = '0;
            end
            HUNT_COLLECT: begin
               if (idx_ff < LAST_SUM_IDX) begin
                  sum_in = sum_ff + req_rx_byte;
                  idx_in = idx_ff + 5'd1;
                  if (wsel_ff < WORD_CNT_CODE) begin
                     shift_word = 1'b1;
                     if (wsub_ff == 2'd2) begin
                        wsub_in = '0;
                        wsel_in = wsel_ff + 3'd1;
                     end else begin
                        wsub_in = wsub_ff + 2'd1;
                     end
                  end
               end else begin
                  // Checksum byte: the frame goes on only if it matches.
                  phase_in = HUNT_FIRST;
                  idx_in   = '0;
                  sum_in   = '0;
                  push     = (req_rx_byte == sum_ff);
               end
            end
            default: begin
               phase_in = (req_rx_byte == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HUNT_FIRST;
         idx_ff   <= '0;
         sum_ff   <= '0;
         wsel_ff  <= '0;
         wsub_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         wsel_ff  <= wsel_in;
         wsub_ff  <= wsub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_word) begin
         words_ff[wsel_ff] <= {words_ff[wsel_ff][WORD_W-9:0], req_rx_byte};
      end
   end

endmodule

FILE: hw/rtl/pmfd_queue.sv
// Two-entry queue of assembled frames between front and back.
module pmfd_queue
   import pmfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  words_type      push_words,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output words_type      head_words,
   output queue_stat_type stat
);

   words_type  mem_ff [QUEUE_DEPTH];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_words = mem_ff[rd_ff];
   assign stat       = '{push: push, pop: pop, count: count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_words;
   end

endmodule

FILE: hw/rtl/pmfd_divider.sv
// Restoring divider, one quotient bit per cycle, saturating fixed-point result.
module pmfd_divider
   import pmfd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] num,
   input  logic [WORD_W-1:0] den,
   output logic              done,
   output logic [Q_W-1:0]    quot
);

   localparam int NUM_W = WORD_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int QX_W  = (NUM_W > Q_W) ? NUM_W : Q_W + 1;

   logic [WORD_W:0]   rem_ff;
   logic [NUM_W-1:0]  dq_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;
   logic [WORD_W:0]   trial;
   logic              fits;
   logic [QX_W-1:0]   qx;

   assign trial = {rem_ff[WORD_W-1:0], dq_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den});
   assign qx    = QX_W'(dq_ff);
   assign done  = done_ff;
   assign quot  = (qx[QX_W-1:Q_W] != '0) ? '1 : qx[Q_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= {num, {FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, den}) : trial;
         dq_ff  <= {dq_ff[NUM_W-2:0], fits};
      end
   end

endmodule

FILE: hw/rtl/pmfd_back.sv
// Back end: three divisions, plausibility check, last good values, result register.
module pmfd_back
   import pmfd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           head_valid,
   input  words_type      head_words,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [Q_W-1:0] rsp_voltage_q,
   output logic [Q_W-1:0] rsp_current_q,
   output logic [Q_W-1:0] rsp_power_q,
   output logic           rsp_data_ok
);

   localparam int PS_W = Q_W + FRAC_BITS;

   back_state_type state_ff, state_in;
   words_type      words_ff;
   logic [1:0]     sel_ff, sel_in;
   logic [Q_W-1:0] v_ff, i_ff, p_ff;
   logic [Q_W-1:0] lg_v_ff, lg_i_ff, lg_p_ff;
   logic [Q_W-1:0] res_v_ff, res_i_ff, res_p_ff;
   logic           res_ok_ff;
   logic [63:0]    prod_ff;
   logic           div_start, div_done;
   logic [Q_W-1:0] div_quot;
   logic [WORD_W-1:0] div_num, div_den;
   logic           zero_den;
   logic [67:0]    pwr_rhs, pwr_lhs;
   logic [63:0]    cur_rhs;
   logic [47:0]    vmin;
   logic           bad;
   logic           out_free;
   logic           rsp_valid_ff;
   logic [Q_W-1:0] out_v_ff, out_i_ff, out_p_ff;
   logic           out_ok_ff;

   assign div_num  = words_ff[{sel_ff, 1'b0}];
   assign div_den  = words_ff[{sel_ff, 1'b1}];
   assign zero_den = (words_ff[1] == '0) || (words_ff[3] == '0) || (words_ff[5] == '0);

   pmfd_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Current times voltage serves both checks; the power side needs 68 bits.
   assign pwr_lhs = 68'({p_ff, {FRAC_BITS{1'b0}}});
   assign pwr_rhs = 68'(prod_ff) * 68'(cfg.power_margin);
   assign cur_rhs = 64'(PS_W'({p_ff, {FRAC_BITS{1'b0}}})) * 64'(cfg.current_margin);
   assign vmin    = 48'(cfg.min_voltage) << FRAC_BITS;
   assign bad     = zero_den || (pwr_lhs > pwr_rhs) || (prod_ff > cur_rhs)
                    || (48'(v_ff) < vmin);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               sel_in   = '0;
               state_in = BK_START;
            end
         end
         BK_START: begin
            div_start = 1'b1;
            state_in  = BK_WAIT;
         end
         BK_WAIT: begin
            if (div_done) begin
               if (sel_ff == 2'd2) begin
                  state_in = BK_MUL;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = BK_START;
               end
            end
         end
         BK_MUL:  state_in = BK_CMP;
         BK_CMP:  state_in = BK_SEND;
         BK_SEND: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sel_ff       <= '0;
         lg_v_ff      <= '0;
         lg_i_ff      <= '0;
         lg_p_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         if (state_ff == BK_CMP && !bad) begin
            lg_v_ff <= v_ff;
            lg_i_ff <= i_ff;
            lg_p_ff <= p_ff;
         end
         if (state_ff == BK_SEND && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) words_ff <= head_words;
      if (state_ff == BK_WAIT && div_done) begin
         case (sel_ff)
            2'd0:    v_ff <= div_quot;
            2'd1:    i_ff <= div_quot;
            default: p_ff <= div_quot;
         endcase
      end
      if (state_ff == BK_MUL) prod_ff <= 64'(v_ff) * 64'(i_ff);
      if (state_ff == BK_CMP) begin
         res_v_ff  <= bad ? lg_v_ff : v_ff;
         res_i_ff  <= bad ? lg_i_ff : i_ff;
         res_p_ff  <= bad ? lg_p_ff : p_ff;
         res_ok_ff <= !bad;
      end
      if (state_ff == BK_SEND && out_free) begin
         out_v_ff  <= res_v_ff;
         out_i_ff  <= res_i_ff;
         out_p_ff  <= res_p_ff;
         out_ok_ff <= res_ok_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_voltage_q = out_v_ff;
   assign rsp_current_q = out_i_ff;
   assign rsp_power_q   = out_p_ff;
   assign rsp_data_ok   = out_ok_ff;

endmodule

FILE: hw/rtl/power_meter_frame_decoder.sv
// The back end runs the one shared bit-serial divider three times per frame.
// Throughput: one byte item per cycle while the frame queue is not full.
// A two-entry frame queue lets byte intake continue while the divider works.
// Synchronous active-high reset clears sync state, queue, last good values and result valid, and reloads the CSRs.
module power_meter_frame_decoder
   import pmfd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_rx_byte,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [Q_W-1:0] rsp_voltage_q,
   output logic [Q_W-1:0] rsp_current_q,
   output logic [Q_W-1:0] rsp_power_q,
   output logic           rsp_data_ok,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_wdata
);

   cfg_type        cfg_ff;
   logic           q_full, push, pop, head_valid;
   words_type      push_words, head_words;
   queue_stat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_voltage    <= MIN_VOLTAGE_RST;
         cfg_ff.power_margin   <= POWER_MARGIN_RST;
         cfg_ff.current_margin <= CURRENT_MARGIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_VOLTAGE:    cfg_ff.min_voltage    <= csr_wdata;
            CSR_POWER_MARGIN:   cfg_ff.power_margin   <= csr_wdata[3:0];
            CSR_CURRENT_MARGIN: cfg_ff.current_margin <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   pmfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push),
      .push_words  (push_words)
   );

   pmfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_words (push_words),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_words (head_words),
      .stat       (q_stat)
   );

   pmfd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head_words    (head_words),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_voltage_q (rsp_voltage_q),
      .rsp_current_q (rsp_current_q),
      .rsp_power_q   (rsp_power_q),
      .rsp_data_ok   (rsp_data_ok)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= 2'(QUEUE_DEPTH))
      else $error("frame queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.push && !q_stat.pop |-> q_stat.count != 2'(QUEUE_DEPTH))
      else $error("frame pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.pop |-> q_stat.count != '0)
      else $error("frame popped from an empty queue");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

FILE: bench/frame_result_checker.sv
`timescale 1ns / 100ps
// Checker for the power meter frame decoder: tracks frames, predicts results, compares them.
module frame_result_checker
   import pmfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_ready,
   input  logic [7:0]     req_rx_byte,
   input  logic           rsp_valid,
   input  logic           rsp_ready,
   input  logic [Q_W-1:0] rsp_voltage_q,
   input  logic [Q_W-1:0] rsp_current_q,
   input  logic [Q_W-1:0] rsp_power_q,
   input  logic           rsp_data_ok,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_wdata,
   output int             fail_count,
   output int             pending,
   output int             results_seen,
   output int             results_ok
);

   typedef struct packed {
      logic [Q_W-1:0] voltage;
      logic [Q_W-1:0] current;
      logic [Q_W-1:0] power;
      logic           ok;
   } reading_type;

   reading_type   expected_readings[$];
   hunt_type      hunt;
   logic [4:0]    byte_pos;
   logic [7:0]    running_sum;
   logic [WORD_W-1:0] word_store[WORD_COUNT];
   logic [Q_W-1:0] good_voltage, good_current, good_power;
   logic [15:0]   min_volt;
   logic [3:0]    pwr_margin;
   logic [5:0]    cur_margin;

   assign pending = expected_readings.size();

   function automatic logic [Q_W-1:0] fixed_quotient(logic [WORD_W-1:0] num,
                                                     logic [WORD_W-1:0] den);
      logic [WORD_W+FRAC_BITS_DEF-1:0] q;
      if (den == 0) return '0;
      q = {num, {FRAC_BITS_DEF{1'b0}}} / den;
      return (q > {Q_W{1'b1}}) ? {Q_W{1'b1}} : q[Q_W-1:0];
   endfunction

   // Full plausibility decision for one frame whose checksum matched.
   function automatic reading_type evaluate_frame();
      reading_type r;
      logic        bad;
      logic [127:0] scaled_p, pwr_limit, iv, cur_limit;
      bad = (word_store[1] == 0) || (word_store[3] == 0) || (word_store[5] == 0);
      r.voltage = fixed_quotient(word_store[0], word_store[1]);
      r.current = fixed_quotient(word_store[2], word_store[3]);
      r.power   = fixed_quotient(word_store[4], word_store[5]);
      scaled_p  = 128'(r.power) << FRAC_BITS_DEF;
      pwr_limit = 128'(pwr_margin) * 128'(r.voltage) * 128'(r.current);
      iv        = 128'(r.current) * 128'(r.voltage);
      cur_limit = scaled_p * 128'(cur_margin);
      if (!bad && (scaled_p > pwr_limit || iv > cur_limit ||
                   128'(r.voltage) < (128'(min_volt) << FRAC_BITS_DEF)))
         bad = 1'b1;
      if (bad) begin
         r.voltage = good_voltage;
         r.current = good_current;
         r.power   = good_power;
         r.ok      = 1'b0;
      end else begin
         good_voltage = r.voltage;
         good_current = r.current;
         good_power   = r.power;
         r.ok         = 1'b1;
      end
      return r;
   endfunction

   task automatic take_byte(input logic [7:0] b);
      int w;
      if (hunt == HUNT_SECOND) begin
         hunt        = (b == SYNC_SECOND) ? HUNT_COLLECT : HUNT_FIRST;
         byte_pos    = '0;
         running_sum = '0;
      end else if (hunt != HUNT_COLLECT) begin
         hunt = (b == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
      end else if (byte_pos < LAST_SUM_IDX) begin
         running_sum = running_sum + b;
         if (byte_pos < 3 * WORD_COUNT) begin
            w = byte_pos / 3;
            word_store[w] = {word_store[w][WORD_W-9:0], b};
         end
         byte_pos = byte_pos + 5'd1;
      end else begin
         // Checksum item: the frame ends here either way.
         hunt     = HUNT_FIRST;
         byte_pos = '0;
         if (b == running_sum) expected_readings.push_back(evaluate_frame());
         running_sum = '0;
      end
   endtask

   task automatic check_field(input string name, input logic [Q_W-1:0] exp_v,
                              input logic [Q_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      reading_type e;
      if (reset) begin
         expected_readings.delete();
         hunt         = HUNT_FIRST;
         byte_pos     = '0;
         running_sum  = '0;
         good_voltage = '0;
         good_current = '0;
         good_power   = '0;
         min_volt     = MIN_VOLTAGE_RST;
         pwr_margin   = POWER_MARGIN_RST;
         cur_margin   = CURRENT_MARGIN_RST;
         fail_count   = 0;
         results_seen = 0;
         results_ok   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_VOLTAGE:    min_volt   = csr_wdata;
               CSR_POWER_MARGIN:   pwr_margin = csr_wdata[3:0];
               CSR_CURRENT_MARGIN: cur_margin = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result, actual %h %h %h %b", $time,
                        rsp_voltage_q, rsp_current_q, rsp_power_q, rsp_data_ok);
               fail_count++;
            end else begin
               e = expected_readings.pop_front();
               if (e.ok) results_ok++;
               check_field("voltage_q", e.voltage, rsp_voltage_q);
               check_field("current_q", e.current, rsp_current_q);
               check_field("power_q", e.power, rsp_power_q);
               check_field("data_ok", Q_W'(e.ok), Q_W'(rsp_data_ok));
            end
         end
         if (req_valid && req_ready) take_byte(req_rx_byte);
      end
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the frame decoder testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
   import pmfd_pkg::*;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   logic [7:0]     req_rx_byte;
   logic           rsp_valid;
   logic           rsp_ready;
   logic [Q_W-1:0] rsp_voltage_q, rsp_current_q, rsp_power_q;
   logic           rsp_data_ok;
   logic           csr_we;
   logic [1:0]     csr_index;
   logic [15:0]    csr_wdata;
   int             fail_count, pending, results_seen, results_ok;
   int             bytes_sent;
   int             burst_left;
   int             holdoff_token;
   int             holdoff_seen;
   int             holdoff_left;
   int             pattern_left;
   int             pattern_mode;

   power_meter_frame_decoder dut (.*);

   frame_result_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 800000);
      $display("timeout");
      $display("testbench: done, errors");
      $finish;
   end

   // Receiver: changing stall patterns, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         holdoff_seen <= 0;
         holdoff_left <= 0;
         pattern_left <= 0;
         pattern_mode <= 0;
      end else if (holdoff_left > 0) begin
         rsp_ready    <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_seen != holdoff_token) begin
         holdoff_seen <= holdoff_token;
         holdoff_left <= 700;
         rsp_ready    <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode <= $urandom_range(0, 2);
            pattern_left <= $urandom_range(50, 400);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (pattern_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [WORD_W-1:0] w[WORD_COUNT], input logic bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      sum = '0;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      for (int k = 0; k < 3 * WORD_COUNT; k++) begin
         b = 8'(w[k / 3] >> (8 * (2 - k % 3)));
         sum += b;
         send_byte(b);
      end
      for (int k = 0; k < 3; k++) begin
         b = 8'($urandom_range(0, 255));
         sum += b;
         send_byte(b);
      end
      send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   // Words that give a voltage, current and power close to consistent.
   task automatic plausible_words(output logic [WORD_W-1:0] w[WORD_COUNT]);
      int volts;
      volts = $urandom_range(1, 300);
      w[1] = 24'($urandom_range(1, 255));
      w[0] = 24'(w[1] * volts);
      w[3] = 24'($urandom_range(1, 255));
      w[2] = 24'($urandom_range(0, w[3] * 5));
      w[5] = w[3];
      w[4] = 24'(volts * w[2] + $urandom_range(0, 3));
   endtask

   task automatic random_frame();
      logic [WORD_W-1:0] w[WORD_COUNT];
      int pick;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
         // Broken sync: the failing byte must not restart the hunt.
         send_byte(SYNC_FIRST);
         send_byte($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom_range(0, 255)));
         send_byte(SYNC_SECOND);
      end
      pick = $urandom_range(0, 99);
      plausible_words(w);
      if (pick >= 70 && pick < 85) begin
         foreach (w[k])
            w[k] = 24'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 300));
      end else if (pick >= 85 && pick < 93) begin
         w[1 + 2 * $urandom_range(0, 2)] = '0;
      end
      send_frame(w, pick >= 93);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   initial begin
      logic [WORD_W-1:0] w[WORD_COUNT];
      logic [15:0] min_set[5];
      logic [15:0] pwr_set[5];
      logic [15:0] cur_set[5];
      min_set        = '{16'd20, 16'd0, 16'd65535, 16'd1, 16'd150};
      pwr_set        = '{16'd2, 16'd15, 16'd1, 16'd0, 16'd3};
      cur_set        = '{16'd10, 16'd63, 16'd1, 16'd0, 16'd7};
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_rx_byte   <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_MIN_VOLTAGE;
      csr_wdata     <= '0;
      holdoff_token  = 0;
      bytes_sent     = 0;
      burst_left     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: saturation, zero divisors, zero voltage, all ones, bad checksum.
      foreach (w[k]) w[k] = (k % 2) ? 24'h1 : 24'hFFFFFF;
      send_frame(w, 1'b0);
      plausible_words(w);
      send_frame(w, 1'b0);
      foreach (w[k]) w[k] = (k % 2) ? 24'h0 : 24'h123456;
      send_frame(w, 1'b0);
      plausible_words(w);
      w[0] = '0;
      send_frame(w, 1'b0);
      foreach (w[k]) w[k] = 24'hFFFFFF;
      send_frame(w, 1'b0);
      plausible_words(w);
      send_frame(w, 1'b1);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'h00);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_MIN_VOLTAGE, ph == 4 ? 16'($urandom_range(0, 400)) : min_set[ph]);
         write_csr(CSR_POWER_MARGIN, pwr_set[ph]);
         write_csr(CSR_CURRENT_MARGIN, cur_set[ph]);
         if (ph == 2) holdoff_token++;
         while (bytes_sent < (ph + 1) * 340) random_frame();
         drain();
      end

      $display("testbench: %0d bytes sent, %0d results checked, %0d of them accepted",
               bytes_sent, results_seen, results_ok);
      $display("over 5 register settings with zero divisors, saturation and bad checksums");
      if (fail_count == 0 && pending == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/pmfd_pkg.sv
hw/rtl/pmfd_front.sv
hw/rtl/pmfd_queue.sv
hw/rtl/pmfd_divider.sv
hw/rtl/pmfd_back.sv
hw/rtl/power_meter_frame_decoder.sv
bench/frame_result_checker.sv
bench/testbench.sv
